// ===== design/pitt_pkg.sv =====
// ---------------------------------------------------------------------------
// Point-in-triangle test: shared package
// Field width, pipeline stage numbering and the stage control bundle.
// ---------------------------------------------------------------------------
package pitt_pkg;

  // Width of every coordinate field on the input channel.
  localparam int FIELD_W = 16;

  // Pipeline stages, numbered from the input side.
  localparam int NUM_STAGES = 7;
  localparam int ST_DIFF    = 1;  // edge vectors and point offset
  localparam int ST_PROD    = 2;  // coordinate products
  localparam int ST_DOT     = 3;  // dot products
  localparam int ST_PART    = 4;  // partial products of the wide multiplies
  localparam int ST_WIDE    = 5;  // full wide products
  localparam int ST_NUM     = 6;  // denominator and barycentric numerators
  localparam int ST_OUT     = 7;  // result register

  typedef logic signed [FIELD_W-1:0] pitt_field_t;

  // Load enables for every stage register, driven by the top level.
  typedef struct packed {
    logic [NUM_STAGES:1] en;
  } pitt_ctrl_t;

endpackage

// ===== design/pitt_in_if.sv =====
// ---------------------------------------------------------------------------
// Point-in-triangle test: input channel
// Valid/ready channel carrying the tested point and the three corners.
// ---------------------------------------------------------------------------
interface pitt_in_if;
  import pitt_pkg::*;

  logic        valid;
  logic        ready;
  pitt_field_t point_x;
  pitt_field_t point_y;
  pitt_field_t point_z;
  pitt_field_t corner_a_x;
  pitt_field_t corner_a_y;
  pitt_field_t corner_a_z;
  pitt_field_t corner_b_x;
  pitt_field_t corner_b_y;
  pitt_field_t corner_b_z;
  pitt_field_t corner_c_x;
  pitt_field_t corner_c_y;
  pitt_field_t corner_c_z;

  modport source (
    output valid, point_x, point_y, point_z,
           corner_a_x, corner_a_y, corner_a_z,
           corner_b_x, corner_b_y, corner_b_z,
           corner_c_x, corner_c_y, corner_c_z,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, point_z,
           corner_a_x, corner_a_y, corner_a_z,
           corner_b_x, corner_b_y, corner_b_z,
           corner_c_x, corner_c_y, corner_c_z,
    output ready
  );

endinterface

// ===== design/pitt_out_if.sv =====
// ---------------------------------------------------------------------------
// Point-in-triangle test: result channel
// Valid/ready channel carrying the inside and degenerate flags.
// ---------------------------------------------------------------------------
interface pitt_out_if;

  logic valid;
  logic ready;
  logic inside_res;
  logic degenerate;

  modport source (
    output valid, inside_res, degenerate,
    input  ready
  );

  modport sink (
    input  valid, inside_res, degenerate,
    output ready
  );

endinterface

// ===== design/point_in_triangle_test_unit.sv =====
// ---------------------------------------------------------------------------
// Point-in-triangle test unit
// Barycentric inside test of a point against a triangle, exact integer form.
// ---------------------------------------------------------------------------
// The unit takes a point P and three corners A, B and C and reports whether P
// lies inside the triangle, using exact integer arithmetic throughout. Each
// input transfer gives exactly one result transfer. While the result channel
// is not stalled a new item may be accepted in every cycle, so the sustained
// rate is one item per cycle. The pipeline has seven register stages: edge
// vectors, coordinate products, dot sums, the partial products and the sum
// of each wide multiply, the numerators, and the result register. Each
// stage only stalls when it holds an item and the stage after it cannot take
// it, so empty slots in the pipeline are filled while a result waits at the
// output. A point on the edges through A counts as inside, a point on the
// edge from B to C counts as outside, and a degenerate triangle (collinear or
// coincident corners) sets degenerate and clears inside_res. Only the low
// COORD_WIDTH bits of each field are used, with bit COORD_WIDTH-1 as the sign;
// for the 2D test give zero in every z.
// ---------------------------------------------------------------------------
module point_in_triangle_test_unit
  import pitt_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  pitt_in_if.sink    in_ch,
  pitt_out_if.source out_ch
);

  // Derived widths: coordinate differences gain one bit, a dot product of
  // three squares gains two more, and the wide products double that.
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int DOT_W  = 2 * DIFF_W + 2;
  localparam int WIDE_W = 2 * DOT_W;

  // -------------------------------------------------------------------------
  // Stage control. A stage may load when it is empty or when the stage after
  // it loads in the same cycle; the result register loads when it is empty
  // or its contents are being transferred.
  // -------------------------------------------------------------------------
  logic [NUM_STAGES:1] vld_r, vld_nxt;
  logic [NUM_STAGES:1] upstream_vld;
  pitt_ctrl_t          ctrl;

  assign upstream_vld = {vld_r[NUM_STAGES-1:1], in_ch.valid};

  always_comb begin
    ctrl.en[NUM_STAGES] = !vld_r[NUM_STAGES] || out_ch.ready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      ctrl.en[k] = !vld_r[k] || ctrl.en[k+1];
    end
  end

  always_comb begin
    for (int k = 1; k <= NUM_STAGES; k++) begin
      vld_nxt[k] = ctrl.en[k] ? upstream_vld[k] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ch.ready = ctrl.en[ST_DIFF];

  // -------------------------------------------------------------------------
  // Coordinate extraction: keep the low COORD_WIDTH bits of each field and
  // read them as a signed value.
  // -------------------------------------------------------------------------
  logic [FIELD_W-1:0]            fld   [12];
  logic signed [COORD_WIDTH-1:0] coord [12];
  logic signed [COORD_WIDTH-1:0] p_c [3], a_c [3], b_c [3], c_c [3];

  assign fld[0]  = in_ch.point_x;
  assign fld[1]  = in_ch.point_y;
  assign fld[2]  = in_ch.point_z;
  assign fld[3]  = in_ch.corner_a_x;
  assign fld[4]  = in_ch.corner_a_y;
  assign fld[5]  = in_ch.corner_a_z;
  assign fld[6]  = in_ch.corner_b_x;
  assign fld[7]  = in_ch.corner_b_y;
  assign fld[8]  = in_ch.corner_b_z;
  assign fld[9]  = in_ch.corner_c_x;
  assign fld[10] = in_ch.corner_c_y;
  assign fld[11] = in_ch.corner_c_z;

  always_comb begin
    for (int k = 0; k < 12; k++) begin
      coord[k] = $signed(COORD_WIDTH'(fld[k]));
    end
    for (int i = 0; i < 3; i++) begin
      p_c[i] = coord[i];
      a_c[i] = coord[3 + i];
      b_c[i] = coord[6 + i];
      c_c[i] = coord[9 + i];
    end
  end

  // -------------------------------------------------------------------------
  // Dot products of the edge vectors e0 = B-A, e1 = C-A and q = P-A.
  // -------------------------------------------------------------------------
  logic signed [DOT_W-1:0] d00, d01, d11, d1q, d0q;

  pitt_dot #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dot (
    .clk   (clk),
    .ctrl  (ctrl),
    .p_i   (p_c),
    .a_i   (a_c),
    .b_i   (b_c),
    .c_i   (c_c),
    .d00_o (d00),
    .d01_o (d01),
    .d11_o (d11),
    .d1q_o (d1q),
    .d0q_o (d0q)
  );

  // -------------------------------------------------------------------------
  // The six wide products that make up D, U and V. d01*d01 has its own
  // multiplier so all six run side by side.
  // -------------------------------------------------------------------------
  logic signed [WIDE_W-1:0] p11_00, p01_01, p00_1q, p01_0q, p11_0q, p01_1q;

  pitt_wmul #(.OP_W(DOT_W)) u_mul_11_00 (
    .clk (clk), .ctrl (ctrl), .a_i (d11), .b_i (d00), .p_o (p11_00)
  );
  pitt_wmul #(.OP_W(DOT_W)) u_mul_01_01 (
    .clk (clk), .ctrl (ctrl), .a_i (d01), .b_i (d01), .p_o (p01_01)
  );
  pitt_wmul #(.OP_W(DOT_W)) u_mul_00_1q (
    .clk (clk), .ctrl (ctrl), .a_i (d00), .b_i (d1q), .p_o (p00_1q)
  );
  pitt_wmul #(.OP_W(DOT_W)) u_mul_01_0q (
    .clk (clk), .ctrl (ctrl), .a_i (d01), .b_i (d0q), .p_o (p01_0q)
  );
  pitt_wmul #(.OP_W(DOT_W)) u_mul_11_0q (
    .clk (clk), .ctrl (ctrl), .a_i (d11), .b_i (d0q), .p_o (p11_0q)
  );
  pitt_wmul #(.OP_W(DOT_W)) u_mul_01_1q (
    .clk (clk), .ctrl (ctrl), .a_i (d01), .b_i (d1q), .p_o (p01_1q)
  );

  // -------------------------------------------------------------------------
  // Denominator, numerators and the final inside test, ending in the result
  // register that drives the result channel.
  // -------------------------------------------------------------------------
  pitt_decide #(
    .OP_W (WIDE_W)
  ) u_decide (
    .clk      (clk),
    .ctrl     (ctrl),
    .p11_00_i (p11_00),
    .p01_01_i (p01_01),
    .p00_1q_i (p00_1q),
    .p01_0q_i (p01_0q),
    .p11_0q_i (p11_0q),
    .p01_1q_i (p01_1q),
    .inside_o (out_ch.inside_res),
    .degen_o  (out_ch.degenerate)
  );

  assign out_ch.valid = vld_r[ST_OUT];

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------

  // An accepted item always occupies the first stage in the next cycle.
  a_accept_lands: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[ST_DIFF]
  ) else $error("accepted item did not reach the first stage");

  // The input is only refused when every stage holds an item.
  a_refuse_only_full: assert property (
    @(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&vld_r)
  ) else $error("input refused while the pipeline had an empty slot");

  // An item in the wide-product stage always moves into an empty numerator stage.
  a_bubble_filled: assert property (
    @(posedge clk) disable iff (!rst_n)
    vld_r[ST_WIDE] && !vld_r[ST_NUM] |=> vld_r[ST_NUM]
  ) else $error("item did not advance into an empty stage");

  // A degenerate triangle is never reported as containing the point.
  a_degen_outside: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.degenerate |-> !out_ch.inside_res
  ) else $error("degenerate triangle reported as inside");

endmodule

// ===== design/pitt_dot.sv =====
// ---------------------------------------------------------------------------
// Point-in-triangle test: dot product front end
// Three stages: edge vectors, coordinate products, and the five dot sums.
// ---------------------------------------------------------------------------
module pitt_dot
  import pitt_pkg::*;
#(
  parameter  int COORD_WIDTH = 16,
  localparam int DIFF_W      = COORD_WIDTH + 1,
  localparam int PROD_W      = 2 * DIFF_W,
  localparam int DOT_W       = PROD_W + 2
) (
  input  logic                     clk,
  input  pitt_ctrl_t               ctrl,
  input  logic signed [COORD_WIDTH-1:0] p_i [3],
  input  logic signed [COORD_WIDTH-1:0] a_i [3],
  input  logic signed [COORD_WIDTH-1:0] b_i [3],
  input  logic signed [COORD_WIDTH-1:0] c_i [3],
  output logic signed [DOT_W-1:0]  d00_o,
  output logic signed [DOT_W-1:0]  d01_o,
  output logic signed [DOT_W-1:0]  d11_o,
  output logic signed [DOT_W-1:0]  d1q_o,
  output logic signed [DOT_W-1:0]  d0q_o
);

  logic signed [DIFF_W-1:0] e0_r [3], e0_nxt [3];
  logic signed [DIFF_W-1:0] e1_r [3], e1_nxt [3];
  logic signed [DIFF_W-1:0] q_r  [3], q_nxt  [3];

  logic signed [PROD_W-1:0] m00_r [3], m00_nxt [3];
  logic signed [PROD_W-1:0] m01_r [3], m01_nxt [3];
  logic signed [PROD_W-1:0] m11_r [3], m11_nxt [3];
  logic signed [PROD_W-1:0] m1q_r [3], m1q_nxt [3];
  logic signed [PROD_W-1:0] m0q_r [3], m0q_nxt [3];

  logic signed [DOT_W-1:0] d00_r, d00_nxt;
  logic signed [DOT_W-1:0] d01_r, d01_nxt;
  logic signed [DOT_W-1:0] d11_r, d11_nxt;
  logic signed [DOT_W-1:0] d1q_r, d1q_nxt;
  logic signed [DOT_W-1:0] d0q_r, d0q_nxt;

  // Edge vectors B-A and C-A, and the point relative to A.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e0_nxt[i] = DIFF_W'(b_i[i]) - DIFF_W'(a_i[i]);
      e1_nxt[i] = DIFF_W'(c_i[i]) - DIFF_W'(a_i[i]);
      q_nxt[i]  = DIFF_W'(p_i[i]) - DIFF_W'(a_i[i]);
    end
  end

  // One product per coordinate and per dot product.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m00_nxt[i] = e0_r[i] * e0_r[i];
      m01_nxt[i] = e1_r[i] * e0_r[i];
      m11_nxt[i] = e1_r[i] * e1_r[i];
      m1q_nxt[i] = e1_r[i] * q_r[i];
      m0q_nxt[i] = e0_r[i] * q_r[i];
    end
  end

  always_comb begin
    d00_nxt = DOT_W'(m00_r[0]) + DOT_W'(m00_r[1]) + DOT_W'(m00_r[2]);
    d01_nxt = DOT_W'(m01_r[0]) + DOT_W'(m01_r[1]) + DOT_W'(m01_r[2]);
    d11_nxt = DOT_W'(m11_r[0]) + DOT_W'(m11_r[1]) + DOT_W'(m11_r[2]);
    d1q_nxt = DOT_W'(m1q_r[0]) + DOT_W'(m1q_r[1]) + DOT_W'(m1q_r[2]);
    d0q_nxt = DOT_W'(m0q_r[0]) + DOT_W'(m0q_r[1]) + DOT_W'(m0q_r[2]);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[ST_DIFF]) begin
      e0_r <= e0_nxt;
      e1_r <= e1_nxt;
      q_r  <= q_nxt;
    end
    if (ctrl.en[ST_PROD]) begin
      m00_r <= m00_nxt;
      m01_r <= m01_nxt;
      m11_r <= m11_nxt;
      m1q_r <= m1q_nxt;
      m0q_r <= m0q_nxt;
    end
    if (ctrl.en[ST_DOT]) begin
      d00_r <= d00_nxt;
      d01_r <= d01_nxt;
      d11_r <= d11_nxt;
      d1q_r <= d1q_nxt;
      d0q_r <= d0q_nxt;
    end
  end

  assign d00_o = d00_r;
  assign d01_o = d01_r;
  assign d11_o = d11_r;
  assign d1q_o = d1q_r;
  assign d0q_o = d0q_r;

endmodule

// ===== design/pitt_wmul.sv =====
// ---------------------------------------------------------------------------
// Point-in-triangle test: two-stage wide signed multiplier
// Splits each operand into halves, registers four partial products, then
// adds them with the proper weights into the full-width product.
// ---------------------------------------------------------------------------
module pitt_wmul
  import pitt_pkg::*;
#(
  parameter  int OP_W  = 36,
  localparam int LO_W  = OP_W / 2,
  localparam int HI_W  = OP_W - LO_W,
  localparam int RES_W = 2 * OP_W
) (
  input  logic                    clk,
  input  pitt_ctrl_t              ctrl,
  input  logic signed [OP_W-1:0]  a_i,
  input  logic signed [OP_W-1:0]  b_i,
  output logic signed [RES_W-1:0] p_o
);

  logic signed [LO_W:0]   a_lo, b_lo;
  logic signed [HI_W-1:0] a_hi, b_hi;

  logic signed [2*LO_W+1:0]    ll_r, ll_nxt;
  logic signed [LO_W+HI_W:0]   lh_r, lh_nxt;
  logic signed [LO_W+HI_W:0]   hl_r, hl_nxt;
  logic signed [2*HI_W-1:0]    hh_r, hh_nxt;
  logic signed [RES_W-1:0]     p_r,  p_nxt;

  // The low halves are unsigned, so they get a zero sign bit.
  assign a_lo = $signed({1'b0, a_i[LO_W-1:0]});
  assign b_lo = $signed({1'b0, b_i[LO_W-1:0]});
  assign a_hi = a_i[OP_W-1:LO_W];
  assign b_hi = b_i[OP_W-1:LO_W];

  always_comb begin
    ll_nxt = a_lo * b_lo;
    lh_nxt = a_lo * b_hi;
    hl_nxt = a_hi * b_lo;
    hh_nxt = a_hi * b_hi;
  end

  always_comb begin
    p_nxt = (RES_W'(hh_r) <<< (2 * LO_W))
          + ((RES_W'(lh_r) + RES_W'(hl_r)) <<< LO_W)
          + RES_W'(ll_r);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[ST_PART]) begin
      ll_r <= ll_nxt;
      lh_r <= lh_nxt;
      hl_r <= hl_nxt;
      hh_r <= hh_nxt;
    end
    if (ctrl.en[ST_WIDE]) begin
      p_r <= p_nxt;
    end
  end

  assign p_o = p_r;

endmodule

// ===== design/pitt_decide.sv =====
// ---------------------------------------------------------------------------
// Point-in-triangle test: decision stages
// Forms the denominator and both numerators, then applies the inside test.
// ---------------------------------------------------------------------------
module pitt_decide
  import pitt_pkg::*;
#(
  parameter  int OP_W  = 72,
  localparam int NUM_W = OP_W + 1,
  localparam int SUM_W = OP_W + 3
) (
  input  logic                   clk,
  input  pitt_ctrl_t             ctrl,
  input  logic signed [OP_W-1:0] p11_00_i,
  input  logic signed [OP_W-1:0] p01_01_i,
  input  logic signed [OP_W-1:0] p00_1q_i,
  input  logic signed [OP_W-1:0] p01_0q_i,
  input  logic signed [OP_W-1:0] p11_0q_i,
  input  logic signed [OP_W-1:0] p01_1q_i,
  output logic                   inside_o,
  output logic                   degen_o
);

  logic signed [NUM_W-1:0] den_r, den_nxt;
  logic signed [NUM_W-1:0] un_r,  un_nxt;
  logic signed [NUM_W-1:0] vn_r,  vn_nxt;
  logic signed [SUM_W-1:0] diff;
  logic                    inside_r, inside_nxt;
  logic                    degen_r,  degen_nxt;

  always_comb begin
    den_nxt = NUM_W'(p11_00_i) - NUM_W'(p01_01_i);
    un_nxt  = NUM_W'(p00_1q_i) - NUM_W'(p01_0q_i);
    vn_nxt  = NUM_W'(p11_0q_i) - NUM_W'(p01_1q_i);
  end

  // Inside when U >= 0, V >= 0 and U + V < D; a zero denominator is never inside.
  always_comb begin
    diff       = SUM_W'(un_r) + SUM_W'(vn_r) - SUM_W'(den_r);
    degen_nxt  = (den_r == '0);
    inside_nxt = !degen_nxt && !un_r[NUM_W-1] && !vn_r[NUM_W-1] && diff[SUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[ST_NUM]) begin
      den_r <= den_nxt;
      un_r  <= un_nxt;
      vn_r  <= vn_nxt;
    end
    if (ctrl.en[ST_OUT]) begin
      inside_r <= inside_nxt;
      degen_r  <= degen_nxt;
    end
  end

  assign inside_o = inside_r;
  assign degen_o  = degen_r;

endmodule
